// File: rtl/core/rcp_pkg.sv
// Shared types and constants for the register copy propagation block.
`timescale 1ns / 1ps

package rcp_pkg;

    localparam int REG_W  = 8;   // register number width
    localparam int LANES  = 16;  // table entries held in one memory row
    localparam int LANE_W = 4;   // bits that select an entry within a row
    localparam int IN_W   = 40;  // packed input transaction width
    localparam int OUT_W  = 32;  // packed output transaction width

    // One decoded instruction as taken from the input stream.
    typedef struct packed {
        logic             predicated;
        logic             is_copy;
        logic             wide_pair;
        logic [REG_W-1:0] dst_reg;
        logic             dst_is_reg;
        logic [REG_W-1:0] src3_reg;
        logic             src3_is_reg;
        logic [REG_W-1:0] src2_reg;
        logic             src2_is_reg;
        logic [REG_W-1:0] src1_reg;
        logic             src1_is_reg;
        logic             block_start;
    } item_t;

    // Sequencer states, one-hot.
    typedef enum logic [6:0] {
        ST_IDLE      = 7'b0000001,
        ST_LOOK_ADDR = 7'b0000010,
        ST_LOOK_DATA = 7'b0000100,
        ST_SWEEP     = 7'b0001000,
        ST_SWEEP_END = 7'b0010000,
        ST_WRITE     = 7'b0100000,
        ST_DONE      = 7'b1000000
    } state_t;

endpackage

// File: rtl/core/rcp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module rcp_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/register_copy_propagation.sv
// Top level of the register copy propagation block: sequencer, copy table and stream ports.
`timescale 1ns / 1ps

// Register copy propagation over a stream of decoded instructions.
//
// Each input transaction on the s_t* channel carries one instruction; each
// output transaction on the m_t* channel carries its three source registers
// after copy substitution plus a flag saying whether any of them changed.
// Exactly one output transaction follows every input transaction, in order.
//
// The copy table keeps one 8-bit source per register in a memory of
// ceil(REG_COUNT/16) rows of 16 entries, with a valid flag per entry in
// flip-flops. The three lookups share the single read port, one after another.
// When the instruction writes a register, the sweep that drops entries copying
// that register reads one row per cycle, so the read port sets the timing.
// An item without a destination skips the sweep, a disabled pass also skips
// the lookups, and only a recorded copy adds a write to the memory.
//
// Reset empties the table and sets propagate_enable. A finished result sits
// in the output register while the block goes on to accept the next
// instruction; if the receiver stalls, the sequencer waits in its final state
// until the output register is free, and s_tready stays low meanwhile.
module register_copy_propagation #(
    parameter int REG_COUNT = 256
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // Input: block_start, src1_is_reg, src1_reg, src2_is_reg, src2_reg,
    // src3_is_reg, src3_reg, dst_is_reg, dst_reg, wide_pair, is_copy,
    // predicated (from bit 0 up).
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [rcp_pkg::IN_W-1:0]  s_tdata,
    // Output: src1_out, src2_out, src3_out, rewritten, zero padding
    // (from bit 0 up).
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [rcp_pkg::OUT_W-1:0] m_tdata,
    // propagate_enable register write
    input  logic                      cfg_we,
    input  logic                      cfg_wdata
);

    import rcp_pkg::*;

    localparam int ROWS     = (REG_COUNT + LANES - 1) / LANES;
    localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int IDX_W    = $clog2(REG_COUNT);
    localparam int ROW_BITS = LANES * REG_W;
    localparam logic [REG_W:0] REG_LIMIT = (REG_W + 1)'(REG_COUNT);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

    // A register number is a table key only below REG_COUNT.
    function automatic logic in_table(input logic [REG_W-1:0] r);
        in_table = ({1'b0, r} < REG_LIMIT);
    endfunction

    function automatic logic [ROW_W-1:0] row_of(input logic [REG_W-1:0] r);
        row_of = r[LANE_W +: ROW_W];
    endfunction

    state_t                 state_reg, state_next;
    item_t                  item_reg;
    logic                   enable_reg;
    logic [REG_COUNT-1:0]   valid_reg, valid_next;
    logic [1:0]             src_idx_reg;
    logic [REG_W-1:0]       res_reg [3];
    logic                   any_reg;
    logic [ROW_W-1:0]       sweep_cnt_reg;
    logic                   sweep_vld_reg;
    logic [ROW_W-1:0]       sweep_row_reg;
    logic [ROW_BITS-1:0]    cap_row_reg;
    logic                   m_tvalid_reg;
    logic [OUT_W-1:0]       m_tdata_reg;

    item_t                  s_item;
    logic                   accept;
    logic                   out_free;
    logic [REG_W-1:0]       dst_pair;
    logic [REG_W-1:0]       cur_reg;
    logic                   cur_is_reg;
    logic [REG_W-1:0]       lane_src;
    logic                   hit;
    logic                   record;
    logic [LANES-1:0]       lane_match;
    logic [REG_COUNT-1:0]   sweep_clr;
    logic                   ram_we;
    logic [ROW_W-1:0]       ram_raddr;
    logic [ROW_BITS-1:0]    ram_wdata;
    logic [ROW_BITS-1:0]    ram_rdata;

    assign s_item   = item_t'(s_tdata);
    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign dst_pair = item_reg.dst_reg + REG_W'(1);

    // Operand under lookup.
    always_comb
    begin
        case (src_idx_reg)
            2'd0:
            begin
                cur_reg    = item_reg.src1_reg;
                cur_is_reg = item_reg.src1_is_reg;
            end
            2'd1:
            begin
                cur_reg    = item_reg.src2_reg;
                cur_is_reg = item_reg.src2_is_reg;
            end
            default:
            begin
                cur_reg    = item_reg.src3_reg;
                cur_is_reg = item_reg.src3_is_reg;
            end
        endcase
    end

    // Chains are never more than one hop: an entry always points at a
    // register that has no entry of its own, so one read resolves a source.
    assign lane_src = ram_rdata[cur_reg[LANE_W-1:0] * REG_W +: REG_W];
    assign hit      = cur_is_reg && in_table(cur_reg) && valid_reg[cur_reg[IDX_W-1:0]];

    assign record = item_reg.dst_is_reg && item_reg.is_copy && item_reg.src1_is_reg &&
                    !item_reg.predicated && !item_reg.wide_pair &&
                    (res_reg[0] != item_reg.dst_reg) && in_table(item_reg.dst_reg);

    // Sweep compare: sixteen entries of the returned row against the destination.
    always_comb
    begin
        for (int j = 0; j < LANES; j++)
        begin
            lane_match[j] = (ram_rdata[j * REG_W +: REG_W] == item_reg.dst_reg) ||
                            (item_reg.wide_pair &&
                             (ram_rdata[j * REG_W +: REG_W] == dst_pair));
        end
        for (int i = 0; i < REG_COUNT; i++)
        begin
            sweep_clr[i] = sweep_vld_reg && (sweep_row_reg == ROW_W'(i / LANES)) &&
                           lane_match[i % LANES];
        end
    end

    // Valid flags: clear-all, key drops, sweep drops, then the new entry.
    always_comb
    begin
        valid_next = valid_reg;
        if (accept && (!enable_reg || s_item.block_start))
        begin
            valid_next = '0;
        end
        if (state_reg == ST_SWEEP_END)
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                if ((item_reg.dst_reg == REG_W'(i)) ||
                    (item_reg.wide_pair && (dst_pair == REG_W'(i))))
                begin
                    valid_next[i] = 1'b0;
                end
            end
        end
        valid_next = valid_next & ~sweep_clr;
        if (state_reg == ST_WRITE)
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                if (item_reg.dst_reg == REG_W'(i))
                begin
                    valid_next[i] = 1'b1;
                end
            end
        end
    end

    // Memory ports: lookups and sweep share the read port.
    assign ram_raddr = (state_reg == ST_LOOK_ADDR) ? row_of(cur_reg) : sweep_cnt_reg;
    assign ram_we    = (state_reg == ST_WRITE);

    always_comb
    begin
        ram_wdata = cap_row_reg;
        ram_wdata[item_reg.dst_reg[LANE_W-1:0] * REG_W +: REG_W] = res_reg[0];
    end

    rcp_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (ROWS),
        .AW    (ROW_W)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (row_of(item_reg.dst_reg)),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = enable_reg ? ST_LOOK_ADDR : ST_DONE;
                end
            end
            ST_LOOK_ADDR:
            begin
                state_next = ST_LOOK_DATA;
            end
            ST_LOOK_DATA:
            begin
                if (src_idx_reg != 2'd2)
                begin
                    state_next = ST_LOOK_ADDR;
                end
                else
                begin
                    state_next = item_reg.dst_is_reg ? ST_SWEEP : ST_DONE;
                end
            end
            ST_SWEEP:
            begin
                if (sweep_cnt_reg == LAST_ROW)
                begin
                    state_next = ST_SWEEP_END;
                end
            end
            ST_SWEEP_END:
            begin
                state_next = record ? ST_WRITE : ST_DONE;
            end
            ST_WRITE:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            enable_reg    <= 1'b1;
            valid_reg     <= '0;
            src_idx_reg   <= '0;
            sweep_cnt_reg <= '0;
            sweep_vld_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            sweep_vld_reg <= (state_reg == ST_SWEEP);
            if (cfg_we)
            begin
                enable_reg <= cfg_wdata;
            end
            if (accept)
            begin
                src_idx_reg <= '0;
            end
            else if (state_reg == ST_LOOK_DATA)
            begin
                src_idx_reg <= src_idx_reg + 2'd1;
            end
            if (state_reg == ST_SWEEP)
            begin
                sweep_cnt_reg <= sweep_cnt_reg + ROW_W'(1);
            end
            else
            begin
                sweep_cnt_reg <= '0;
            end
            if ((state_reg == ST_DONE) && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg   <= s_item;
            res_reg[0] <= s_item.src1_reg;
            res_reg[1] <= s_item.src2_reg;
            res_reg[2] <= s_item.src3_reg;
            any_reg    <= 1'b0;
        end
        else if ((state_reg == ST_LOOK_DATA) && hit)
        begin
            res_reg[src_idx_reg] <= lane_src;
            if (lane_src != cur_reg)
            begin
                any_reg <= 1'b1;
            end
        end
        sweep_row_reg <= sweep_cnt_reg;
        if (sweep_vld_reg && (sweep_row_reg == row_of(item_reg.dst_reg)))
        begin
            cap_row_reg <= ram_rdata;
        end
        if ((state_reg == ST_DONE) && out_free)
        begin
            m_tdata_reg <= {7'b0, any_reg, res_reg[2], res_reg[1], res_reg[0]};
        end
    end

    // A disabled pass leaves the copy table empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !enable_reg) |=> (valid_reg == '0))
        else $error("copy table not emptied by a disabled transaction");

    // Sweep data only returns while the sweep is running.
    assert property (@(posedge clk) disable iff (!rst_n)
        sweep_vld_reg |-> ((state_reg == ST_SWEEP) || (state_reg == ST_SWEEP_END)))
        else $error("sweep data outside the sweep");

    // A recorded copy leaves its entry valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> valid_reg[item_reg.dst_reg[IDX_W-1:0]])
        else $error("recorded copy entry not valid");

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the register copy propagation block.
`timescale 1ns / 1ps

module testbench;
    import rcp_pkg::*;

    localparam int     CLK_HALF       = 6;
    localparam int     RESET_CYCLES   = 12;
    localparam int     NUM_REGS       = 256;
    localparam int     CHASE_LIMIT    = 256;
    localparam int     SETTLE_CYCLES  = 40;
    localparam int     ENABLED_ITEMS  = 400;
    localparam int     DISABLED_ITEMS = 50;
    localparam int     POOL_SIZE      = 8;
    localparam longint TIMEOUT_NS     = 64'd10_000_000;

    // One result transaction as laid out in m_tdata, from bit 0 up.
    typedef struct packed {
        logic             rewritten;
        logic [REG_W-1:0] src3;
        logic [REG_W-1:0] src2;
        logic [REG_W-1:0] src1;
    } operands_t;

    // Tracks the copy table alongside the block and holds the operands that
    // each accepted instruction should come back with.
    class copy_prop_scoreboard;
        bit             copy_valid [NUM_REGS];
        bit [REG_W-1:0] copy_src   [NUM_REGS];
        bit             enabled;
        operands_t      expected_operands [$];
        int             mismatches;

        function new();
            clear_table();
            enabled    = 1'b1;
            mismatches = 0;
        endfunction

        function void clear_table();
            foreach (copy_valid[i])
            begin
                copy_valid[i] = 1'b0;
                copy_src[i]   = '0;
            end
        endfunction

        function void set_enable(bit value);
            enabled = value;
        endfunction

        function int pending();
            return expected_operands.size();
        endfunction

        // Follows the copy chain from a register; in practice one hop at most.
        function bit [REG_W-1:0] resolve(bit [REG_W-1:0] r);
            int hops;
            hops = 0;
            while (hops < CHASE_LIMIT && copy_valid[r])
            begin
                r = copy_src[r];
                hops++;
            end
            return r;
        endfunction

        function void note_instruction(item_t it);
            bit [REG_W-1:0] regs    [3];
            bit             is_reg  [3];
            bit [REG_W-1:0] res     [3];
            bit [REG_W-1:0] partner;
            bit             any;
            operands_t      exp_ops;

            regs    = '{it.src1_reg, it.src2_reg, it.src3_reg};
            is_reg  = '{it.src1_is_reg, it.src2_is_reg, it.src3_is_reg};
            res     = regs;
            any     = 1'b0;
            partner = it.dst_reg + 1'b1;

            if (!enabled)
            begin
                // Writes made while disabled are not tracked, so nothing survives.
                clear_table();
            end
            else
            begin
                if (it.block_start)
                    clear_table();
                for (int k = 0; k < 3; k++)
                begin
                    if (is_reg[k])
                    begin
                        res[k] = resolve(regs[k]);
                        if (res[k] != regs[k])
                            any = 1'b1;
                    end
                end
                if (it.dst_is_reg)
                begin
                    copy_valid[it.dst_reg] = 1'b0;
                    if (it.wide_pair)
                        copy_valid[partner] = 1'b0;
                    for (int i = 0; i < NUM_REGS; i++)
                    begin
                        if (copy_valid[i] && (copy_src[i] == it.dst_reg ||
                            (it.wide_pair && copy_src[i] == partner)))
                            copy_valid[i] = 1'b0;
                    end
                    if (it.is_copy && it.src1_is_reg && !it.predicated && !it.wide_pair &&
                        res[0] != it.dst_reg && int'(it.dst_reg) < NUM_REGS)
                    begin
                        copy_valid[it.dst_reg] = 1'b1;
                        copy_src[it.dst_reg]   = res[0];
                    end
                end
            end

            exp_ops.src1      = res[0];
            exp_ops.src2      = res[1];
            exp_ops.src3      = res[2];
            exp_ops.rewritten = any;
            expected_operands.push_back(exp_ops);
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            mismatches++;
        endtask

        task check_result(logic [OUT_W-1:0] data);
            operands_t got;
            operands_t want;
            got = data[$bits(operands_t)-1:0];
            if (expected_operands.size() == 0)
            begin
                report_mismatch("result transaction with no instruction outstanding");
                return;
            end
            want = expected_operands.pop_front();
            if (got.src1 !== want.src1)
                report_mismatch($sformatf("src1_out %0d, expected %0d", got.src1, want.src1));
            if (got.src2 !== want.src2)
                report_mismatch($sformatf("src2_out %0d, expected %0d", got.src2, want.src2));
            if (got.src3 !== want.src3)
                report_mismatch($sformatf("src3_out %0d, expected %0d", got.src3, want.src3));
            if (got.rewritten !== want.rewritten)
                report_mismatch($sformatf("rewritten %0b, expected %0b",
                                          got.rewritten, want.rewritten));
        endtask
    endclass

    logic              clk;
    logic              rst_n     = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic [IN_W-1:0]   s_tdata   = '0;
    logic              m_tready  = 1'b0;
    logic              cfg_we    = 1'b0;
    logic              cfg_wdata = 1'b0;
    wire               s_tready;
    wire               m_tvalid;
    wire  [OUT_W-1:0]  m_tdata;

    int                sender_idle_pct   = 20;
    int                receiver_idle_pct = 46;
    bit [REG_W-1:0]    pool_base         = '0;
    copy_prop_scoreboard copy_sb         = new();

    register_copy_propagation #(
        .REG_COUNT (NUM_REGS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Receiving side: check each accepted result, then decide whether to stall.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                copy_sb.check_result(m_tdata);
            m_tready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic item_t instr(bit bs, bit s1i, int s1, bit s2i, int s2, bit s3i, int s3,
                                    bit di, int d, bit wp, bit cp, bit pr);
        item_t it;
        it.block_start = bs;
        it.src1_is_reg = s1i;
        it.src1_reg    = REG_W'(s1);
        it.src2_is_reg = s2i;
        it.src2_reg    = REG_W'(s2);
        it.src3_is_reg = s3i;
        it.src3_reg    = REG_W'(s3);
        it.dst_is_reg  = di;
        it.dst_reg     = REG_W'(d);
        it.wide_pair   = wp;
        it.is_copy     = cp;
        it.predicated  = pr;
        return it;
    endfunction

    // Most registers come from a small window so that copies are read back
    // and overwritten often; the window sits on the wrap point now and then.
    function automatic bit [REG_W-1:0] pick_register();
        if ($urandom_range(99) < 75)
            return pool_base + REG_W'($urandom_range(POOL_SIZE - 1));
        return REG_W'($urandom_range(255));
    endfunction

    function automatic item_t random_instruction();
        item_t       it;
        logic [63:0] raw;
        if ($urandom_range(99) < 4)
            pool_base = ($urandom_range(99) < 25) ? REG_W'(NUM_REGS - POOL_SIZE / 2)
                                                  : REG_W'($urandom_range(255));
        if ($urandom_range(99) < 10)
        begin
            // Unshaped noise: every field drawn at random.
            raw = {$urandom(), $urandom()};
            it  = raw[IN_W-1:0];
            return it;
        end
        it.block_start = ($urandom_range(99) < 4);
        it.src1_is_reg = ($urandom_range(99) < 90);
        it.src1_reg    = pick_register();
        it.src2_is_reg = ($urandom_range(99) < 75);
        it.src2_reg    = pick_register();
        it.src3_is_reg = ($urandom_range(99) < 50);
        it.src3_reg    = pick_register();
        it.dst_is_reg  = ($urandom_range(99) < 85);
        it.dst_reg     = pick_register();
        it.wide_pair   = ($urandom_range(99) < 15);
        it.is_copy     = ($urandom_range(99) < 45);
        it.predicated  = ($urandom_range(99) < 12);
        return it;
    endfunction

    // Presents one instruction, possibly after a gap, and holds it until taken.
    // It returns in the time step of the handshake so that the caller can drive
    // the next instruction, or lower s_tvalid, in that same step.
    task automatic send_item(item_t it);
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= it;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        copy_sb.note_instruction(it);
    endtask

    task automatic wait_until_idle();
        s_tvalid <= 1'b0;
        while (copy_sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_enable(bit value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        copy_sb.set_enable(value);
    endtask

    task automatic run_directed();
        item_t seq [$];
        // A copy, then reads of the copied register through each operand.
        seq.push_back(instr(0, 1, 0, 0, 0, 0, 0, 1, 1, 0, 1, 0));
        seq.push_back(instr(0, 1, 1, 1, 1, 1, 1, 0, 0, 0, 0, 0));
        // A non-register operand is never substituted.
        seq.push_back(instr(0, 1, 1, 0, 1, 1, 1, 0, 0, 0, 0, 0));
        // Copy of a copy records the already substituted source.
        seq.push_back(instr(0, 1, 1, 0, 0, 0, 0, 1, 255, 0, 1, 0));
        seq.push_back(instr(0, 0, 0, 1, 255, 0, 0, 0, 0, 0, 0, 0));
        // A 64-bit write to the top register also hits register 0 by wrap-round,
        // which removes both entries that copy register 0.
        seq.push_back(instr(0, 0, 0, 0, 0, 0, 0, 1, 255, 1, 0, 0));
        seq.push_back(instr(0, 1, 1, 1, 255, 1, 0, 0, 0, 0, 0, 0));
        // Predicated copy is not recorded.
        seq.push_back(instr(0, 1, 3, 0, 0, 0, 0, 1, 2, 0, 1, 1));
        seq.push_back(instr(0, 1, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // Copy of a register onto itself.
        seq.push_back(instr(0, 1, 4, 0, 0, 0, 0, 1, 4, 0, 1, 0));
        seq.push_back(instr(0, 1, 4, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // 64-bit copy is not recorded.
        seq.push_back(instr(0, 1, 6, 0, 0, 0, 0, 1, 5, 1, 1, 0));
        seq.push_back(instr(0, 1, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // Copy without a register destination is not recorded.
        seq.push_back(instr(0, 1, 8, 0, 0, 0, 0, 0, 7, 0, 1, 0));
        seq.push_back(instr(0, 1, 7, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // A block start empties the table before the lookup.
        seq.push_back(instr(0, 1, 10, 0, 0, 0, 0, 1, 9, 0, 1, 0));
        seq.push_back(instr(1, 1, 9, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // Writing a source register removes every entry that copies it.
        seq.push_back(instr(0, 1, 12, 0, 0, 0, 0, 1, 11, 0, 1, 0));
        seq.push_back(instr(0, 1, 11, 0, 0, 0, 0, 1, 13, 0, 1, 0));
        seq.push_back(instr(0, 1, 13, 1, 11, 0, 0, 0, 0, 0, 0, 0));
        seq.push_back(instr(0, 0, 0, 0, 0, 0, 0, 1, 12, 0, 0, 0));
        seq.push_back(instr(0, 1, 11, 1, 13, 0, 0, 0, 0, 0, 0, 0));
        // Copy whose first operand is not a register.
        seq.push_back(instr(0, 0, 20, 0, 0, 0, 0, 1, 21, 0, 1, 0));
        seq.push_back(instr(0, 1, 21, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // Every field at its extremes.
        seq.push_back(instr(1, 1, 255, 1, 255, 1, 255, 1, 255, 1, 1, 1));
        seq.push_back(instr(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        foreach (seq[i])
            send_item(seq[i]);
    endtask

    // Three idling regimes; each runs with rewriting on, then with it off.
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    sender_idle_pct   = 20;
                    receiver_idle_pct = 46;
                end
                1:
                begin
                    sender_idle_pct   = 46;
                    receiver_idle_pct = 20;
                end
                default:
                begin
                    sender_idle_pct   = 0;
                    receiver_idle_pct = 0;
                end
            endcase
            write_enable(1'b1);
            if (phase == 0)
                run_directed();
            repeat (ENABLED_ITEMS) send_item(random_instruction());
            wait_until_idle();
            write_enable(1'b0);
            repeat (DISABLED_ITEMS) send_item(random_instruction());
            wait_until_idle();
        end
        if (copy_sb.pending() != 0)
            copy_sb.report_mismatch($sformatf("%0d results never arrived", copy_sb.pending()));
        if (copy_sb.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
